/* rtl/wpm_pkg.sv */
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; every other file of the block but wpm_out_if imports this package.
`default_nettype none

package wpm_pkg;

  // Largest pattern the matcher holds by default
  localparam int PATTERN_MAX_DEF = 16;

  // Configuration port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int LENGTH_W   = 5;

  // Pattern metacharacters
  localparam logic [7:0] CHAR_ANY  = 8'h3F;
  localparam logic [7:0] CHAR_STAR = 8'h2A;

  // Request commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef logic [7:0] name_byte_t;

  // Register indexes, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

/* rtl/wpm_in_if.sv */
// Request channel of the wildcard pattern matcher: one name byte or end of name.
// Depends on wpm_pkg.
`default_nettype none

interface wpm_in_if import wpm_pkg::*;;
  logic       valid;
  logic       ready;
  logic       command;
  name_byte_t name_byte;

  modport source (output valid, output command, output name_byte, input ready);
  modport sink   (input valid, input command, input name_byte, output ready);
endinterface

`default_nettype wire

/* rtl/wpm_out_if.sv */
// Result channel of the wildcard pattern matcher: one match flag per name.
// No dependencies.
`default_nettype none

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

`default_nettype wire

/* rtl/wpm_apb_regs.sv */
// APB register file of the matcher: pattern bytes and pattern length.
// Depends on wpm_pkg; pulses cfg_write on every write to a known register.
`default_nettype none

module wpm_apb_regs import wpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_DATA_W-1:0] pattern_low,
  output logic [CFG_DATA_W-1:0] pattern_high,
  output logic [LENGTH_W-1:0]   pattern_length,
  output logic                  cfg_write
);

  reg_index_t reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en     = psel && penable && pwrite && pready;

  // Known-register write strobe
  always_comb begin
    case (reg_index)
      REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH: cfg_write = wr_en;
      default: cfg_write = 1'b0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_index)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(pattern_length);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/wildcard_pattern_matcher.sv */
// Wildcard pattern matcher: '?' matches one byte, '*' any run of bytes.
// Throughput: one request per cycle, byte or end of name, while no stalled result
// holds back the request channel; the live-position vector is updated and star-closed
// in the single compute stage. Result path: an end-of-name request is registered in the
// input register, then its flag in the result register, or in the skid stage on a stall.
// Reset: empty pattern, live vector at its restart value, no result pending.
// Depends on wpm_pkg, wpm_in_if, wpm_out_if and wpm_apb_regs.
`default_nettype none

module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  wpm_in_if.sink                items,
  wpm_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int POS_W = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [CFG_DATA_W-1:0]   pattern_low;
  logic [CFG_DATA_W-1:0]   pattern_high;
  logic [LENGTH_W-1:0]     pattern_length;
  logic                    cfg_write;
  logic [2*CFG_DATA_W-1:0] pattern_all;

  logic [LEN_W-1:0]        used_len;
  logic [PATTERN_MAX-1:0]  in_use;
  logic [PATTERN_MAX-1:0]  star_mask;
  logic [PATTERN_MAX-1:0]  hit_mask;
  logic [POS_W-1:0]        restart_vec;
  logic [POS_W-1:0]        base_vec;
  logic [POS_W-1:0]        step_vec;
  logic [POS_W-1:0]        closed_vec;

  logic                    in_fire;
  logic                    pipe_valid;
  logic                    pipe_command;
  name_byte_t              pipe_byte;
  logic                    restart_pend;
  logic [POS_W-1:0]        live;
  logic                    push;
  logic                    push_matched;
  logic                    out_valid;
  logic                    out_matched;
  logic                    skid_valid;
  logic                    skid_matched;

  wpm_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pattern_low    (pattern_low),
    .pattern_high   (pattern_high),
    .pattern_length (pattern_length),
    .cfg_write      (cfg_write)
  );

  assign pattern_all = {pattern_high, pattern_low};

  // Effective pattern length, clamped to the storage size
  always_comb begin
    if (pattern_length > LENGTH_W'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = pattern_length[LEN_W-1:0];
    end
  end

  // Per-position classification against the current byte
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_use[i]    = LEN_W'(i) < used_len;
      star_mask[i] = in_use[i] && (pattern_all[8*i +: 8] == CHAR_STAR);
      hit_mask[i]  = in_use[i] && !star_mask[i] &&
                     ((pattern_all[8*i +: 8] == CHAR_ANY) ||
                      (pattern_all[8*i +: 8] == pipe_byte));
    end
  end

  // Restart vector: position zero live, closed over leading stars
  always_comb begin
    restart_vec = POS_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      restart_vec[i+1] = restart_vec[i+1] | (restart_vec[i] & star_mask[i]);
    end
  end

  assign base_vec = restart_pend ? restart_vec : live;

  // One byte step: stars hold their position, hits advance by one
  always_comb begin
    step_vec = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      step_vec[i]   = step_vec[i]   | (base_vec[i] & star_mask[i]);
      step_vec[i+1] = step_vec[i+1] | (base_vec[i] & hit_mask[i]);
    end
  end

  // Star closure ripple
  always_comb begin
    closed_vec = step_vec;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      closed_vec[i+1] = closed_vec[i+1] | (closed_vec[i] & star_mask[i]);
    end
  end

  // Request acceptance: the compute stage never stalls, so hold back only while the
  // skid stage is full or a match flag is about to land behind a stalled result
  assign items.ready = !skid_valid &&
                       !(push && out_valid && !results.ready);
  assign in_fire     = items.valid && items.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pipe_command <= items.command;
      pipe_byte    <= items.name_byte;
    end
  end

  // Live-position state; a restart is deferred and applied on first use
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_pend <= 1'b1;
    end else if (cfg_write) begin
      restart_pend <= 1'b1;
    end else if (pipe_valid) begin
      if (pipe_command == CMD_END) begin
        restart_pend <= 1'b1;
      end else begin
        restart_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid && (pipe_command == CMD_BYTE)) begin
      live <= closed_vec;
    end
  end

  assign push         = pipe_valid && (pipe_command == CMD_END);
  assign push_matched = base_vec[used_len];

  // Result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_matched <= skid_matched;
      end else if (push) begin
        out_matched <= push_matched;
      end
    end else if (push) begin
      skid_matched <= push_matched;
    end
  end

  assign results.valid   = out_valid;
  assign results.matched = out_matched;

endmodule

`default_nettype wire

/* sim/wildcard_pattern_matcher_test.sv */
// Self-checking testbench for the wildcard pattern matcher: streams names,
// predicts each match flag and checks it.
// Depends on wpm_pkg, wpm_in_if, wpm_out_if and the wildcard_pattern_matcher RTL.
`timescale 1ns / 100ps

import wpm_pkg::*;

// Glob predictor and store of expected match flags
class match_scoreboard;
  name_byte_t               pattern[PATTERN_MAX_DEF];
  logic [LENGTH_W-1:0]      length_reg;
  logic [PATTERN_MAX_DEF:0] live;
  bit                       expected_matches[$];
  int                       mismatches;
  int                       names_done;
  int                       hits;

  function new();
    foreach (pattern[i]) pattern[i] = '0;
    length_reg = '0;
    live = star_close(1);
  endfunction

  // Pattern bytes in use; oversized lengths clamp to the maximum
  function int unsigned span();
    return (length_reg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : length_reg;
  endfunction

  // A live star also makes the position after it live
  function logic [PATTERN_MAX_DEF:0] star_close(logic [PATTERN_MAX_DEF:0] v);
    int unsigned n;
    n = span();
    for (int i = 0; i < n; i++)
      if (v[i] && pattern[i] == CHAR_STAR) v[i+1] = 1'b1;
    return v;
  endfunction

  // Any known register write restarts the current name
  function void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PATTERN_LOW: begin
        for (int k = 0; k < 8; k++) pattern[k] = data[8*k +: 8];
      end
      REG_PATTERN_HIGH: begin
        for (int k = 0; k < 8; k++) pattern[8+k] = data[8*k +: 8];
      end
      REG_PATTERN_LENGTH: begin
        length_reg = data[LENGTH_W-1:0];
      end
      default: begin
        return;
      end
    endcase
    live = star_close(1);
  endfunction

  // Advance the live vector for one accepted request
  function void note_request(logic cmd, name_byte_t b);
    logic [PATTERN_MAX_DEF:0] next;
    int unsigned n;
    n = span();
    next = '0;
    if (cmd == CMD_END) begin
      expected_matches.push_back(live[n]);
      live = star_close(1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (live[i]) begin
        if (pattern[i] == CHAR_STAR) next[i] = 1'b1;
        else if (pattern[i] == CHAR_ANY || pattern[i] == b) next[i+1] = 1'b1;
      end
    end
    live = star_close(next);
  endfunction

  task report(string msg);
    $display("  mismatch: %s", msg);
    mismatches++;
  endtask

  task check_result(logic matched);
    bit want;
    if (expected_matches.size() == 0) begin
      report($sformatf("result with none pending, matched=%0b", matched));
      return;
    end
    want = expected_matches.pop_front();
    names_done++;
    if (want) hits++;
    if (matched !== want)
      report($sformatf("name %0d: matched=%0b, expected %0b", names_done, matched, want));
  endtask

  function int pending();
    return expected_matches.size();
  endfunction
endclass

module wildcard_pattern_matcher_test;
  localparam int         HALF_PERIOD    = 5;
  localparam int         IDLE_PCT       = 18;
  localparam int         ITEM_TARGET    = 600;
  localparam int         SETTLE         = 4;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] REG_UNUSED     = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  wpm_in_if  req_ch ();
  wpm_out_if res_ch ();

  wildcard_pattern_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .items   (req_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  match_scoreboard sb;
  bit              steady;
  int              requests_sent;
  int              idle_cycles;
  int              settings_loaded;
  name_byte_t      pat[PATTERN_MAX_DEF];
  int unsigned     pat_span;
  name_byte_t      name_q[$];

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Monitors: feed the predictor, check results, track progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.command, req_ch.name_byte);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.matched);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink with random stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on lack of progress
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One request, with an optional random gap ahead of it
  task send_request(logic cmd, name_byte_t b);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.name_byte <= b;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  // Stop sending and wait for every pending result, then idle for the given extra margin
  task drain(int extra);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task cfg_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write pat[] and a length, in random register order; upper length bits are noise
  task load_pattern(logic [LENGTH_W-1:0] len);
    logic [CFG_DATA_W-1:0] lo, hi, len_word;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat[k];
      hi[8*k +: 8] = pat[8+k];
    end
    len_word = {$urandom, $urandom};
    len_word[LENGTH_W-1:0] = len;
    drain(SETTLE);
    if ($urandom_range(1)) begin
      cfg_write(REG_PATTERN_LOW, lo);
      cfg_write(REG_PATTERN_HIGH, hi);
      cfg_write(REG_PATTERN_LENGTH, len_word);
    end else begin
      cfg_write(REG_PATTERN_LENGTH, len_word);
      cfg_write(REG_PATTERN_HIGH, hi);
      cfg_write(REG_PATTERN_LOW, lo);
    end
    pat_span = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
    settings_loaded++;
  endtask

  task send_name(bit close);
    foreach (name_q[i]) send_request(CMD_BYTE, name_q[i]);
    if (close) send_request(CMD_END, name_byte_t'($urandom));
  endtask

  // Small alphabet for frequent hits, full-range bytes for bit coverage
  function automatic name_byte_t pick_byte();
    case ($urandom_range(7))
      0:       return "a";
      1:       return "b";
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return name_byte_t'($urandom);
    endcase
  endfunction

  function automatic name_byte_t pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return CHAR_STAR;
    if (r < 40) return CHAR_ANY;
    return pick_byte();
  endfunction

  // Name that fits the current pattern, sometimes corrupted
  function automatic void build_name();
    int unsigned pos;
    name_q.delete();
    for (int i = 0; i < pat_span; i++) begin
      if (pat[i] == CHAR_STAR) begin
        repeat ($urandom_range(3)) name_q.push_back(pick_byte());
      end else if (pat[i] == CHAR_ANY) begin
        name_q.push_back(name_byte_t'($urandom));
      end else begin
        name_q.push_back(pat[i]);
      end
    end
    if ($urandom_range(99) < 30) begin
      pos = (name_q.size() > 0) ? $urandom_range(name_q.size() - 1) : 0;
      case ($urandom_range(2))
        0: if (name_q.size() > 0) name_q[pos] = name_byte_t'($urandom);
        1: name_q.push_back(pick_byte());
        default: if (name_q.size() > 0) name_q.delete(pos);
      endcase
    end
  endfunction

  initial begin
    int start_count;
    int phase;
    int unsigned r;
    sb = new();
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_BYTE;
    req_ch.name_byte = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    steady  = 1'b0;
    requests_sent   = 0;
    settings_loaded = 0;
    pat_span        = 0;
    foreach (pat[i]) pat[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pattern after reset: only the empty name matches
    send_request(CMD_END, 8'hFF);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_END, 8'h00);

    // "a*b?", with a write to an unused address in mid-name
    pat[0] = "a";
    pat[1] = CHAR_STAR;
    pat[2] = "b";
    pat[3] = CHAR_ANY;
    load_pattern(LENGTH_W'(4));
    send_request(CMD_BYTE, "a");
    send_request(CMD_BYTE, "x");
    drain(SETTLE);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    send_request(CMD_BYTE, "b");
    send_request(CMD_BYTE, "z");
    send_request(CMD_END, 8'h00);
    name_q = '{"a", "b"};
    send_name(1);
    send_request(CMD_END, 8'hFF);

    // Zero byte as a literal, trailing star, restart on register write
    pat[0] = 8'h00;
    pat[1] = CHAR_STAR;
    load_pattern(LENGTH_W'(2));
    name_q = '{8'h00};
    send_name(1);
    name_q = '{8'h00, 8'hFF, CHAR_STAR};
    send_name(1);
    send_request(CMD_BYTE, 8'h01);
    drain(SETTLE);
    cfg_write(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
    name_q = '{8'h00};
    send_name(1);

    // Length beyond the maximum, all stars
    foreach (pat[i]) pat[i] = CHAR_STAR;
    load_pattern(LENGTH_W'(31));
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_END, 8'h00);
    send_request(CMD_END, 8'h00);

    // Random patterns, mostly well-formed names
    start_count = requests_sent;
    phase = 0;
    while (requests_sent - start_count < ITEM_TARGET) begin
      steady = (phase == 4 || phase == 5);
      r = $urandom_range(99);
      if ($urandom_range(7) == 0) begin
        foreach (pat[i]) pat[i] = name_byte_t'($urandom);
      end else begin
        foreach (pat[i]) pat[i] = pick_pattern_byte();
      end
      if (r < 8)
        load_pattern(LENGTH_W'($urandom_range(31, 17)));
      else if (r < 16)
        load_pattern(LENGTH_W'(PATTERN_MAX_DEF));
      else
        load_pattern(LENGTH_W'($urandom_range(15)));
      repeat ($urandom_range(10, 4)) begin
        build_name();
        send_name(1);
      end
      // Hold off until the matcher has answered everything
      if (phase == 2) begin
        drain(0);
        build_name();
        send_name(1);
      end
      // Leave a name open; the next register write restarts it
      if ($urandom_range(3) == 0) begin
        build_name();
        send_name(0);
      end
      phase++;
    end
    steady = 1'b0;

    drain(8);
    $display("%0d requests, %0d names checked (%0d matched), %0d pattern settings",
             requests_sent, sb.names_done, sb.hits, settings_loaded);
    $display("covered empty, oversized, star-only and zero-byte patterns and mid-name restarts");
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
